/* sv/sdi_pkg.sv */
// Shared types and constants for the stroke dab interpolator.
package sdi_pkg;
    localparam int MAX_DABS = 64;
    localparam int MAX_CANVAS = 4096;
    localparam int CNT_W = $clog2(MAX_DABS + 1);
    localparam int IDX_W = (MAX_DABS > 1) ? $clog2(MAX_DABS) : 1;
    localparam int NORM_W = 16;
    localparam int SIZE_W = 13;
    localparam int SPC_W = 16;
    localparam int POS_W = 20;
    localparam int VEC_W = 21;
    localparam int REG_W = 16;
    localparam int RIDX_W = 2;
    localparam int QDEPTH = 2;

    localparam logic [RIDX_W-1:0] REG_WIDTH = 2'd0;
    localparam logic [RIDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [RIDX_W-1:0] REG_SPACING = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic             start;
    } point_t;

    // one segment job handed from the front end to the dab generator
    typedef struct packed {
        logic [POS_W-1:0] prev_x;
        logic [POS_W-1:0] prev_y;
        logic [VEC_W-1:0] dx;
        logic [VEC_W-1:0] dy;
        logic [CNT_W-1:0] cnt;
        logic             clip;
    } seg_t;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_SCALE,
        FE_SQ,
        FE_SQRT,
        FE_DIV,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_MUL,
        BE_DIV,
        BE_OUT
    } be_state_t;
endpackage

/* sv/sdi_if.sv */
// Valid/ready channel interfaces for points, dabs and configuration writes.
interface sdi_point_if;
    logic                        valid;
    logic                        ready;
    logic [sdi_pkg::NORM_W-1:0]  norm_x;
    logic [sdi_pkg::NORM_W-1:0]  norm_y;
    logic                        stroke_start;
    modport source (output valid, norm_x, norm_y, stroke_start, input ready);
    modport sink (input valid, norm_x, norm_y, stroke_start, output ready);
endinterface

interface sdi_dab_if;
    logic                       valid;
    logic                       ready;
    logic [sdi_pkg::POS_W-1:0]  dab_x;
    logic [sdi_pkg::POS_W-1:0]  dab_y;
    logic [sdi_pkg::VEC_W-1:0]  seg_dx;
    logic [sdi_pkg::VEC_W-1:0]  seg_dy;
    logic                       last;
    logic                       clipped;
    modport source (output valid, dab_x, dab_y, seg_dx, seg_dy, last, clipped,
                    input ready);
    modport sink (input valid, dab_x, dab_y, seg_dx, seg_dy, last, clipped,
                  output ready);
endinterface

interface sdi_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sdi_pkg::RIDX_W-1:0]  index;
    logic [sdi_pkg::REG_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/stroke_dab_interpolator.sv */
// Top level of the stroke dab interpolator: config registers and the two halves.
// Points are scaled to Q12.8 pixels; each non-first point yields 1..MAX_DABS dabs.
// For a segment point the front end goes through scale, square, a 23-step bitwise
// square root, a 21-step spacing division and a hand-off before it is idle again;
// the back end, per dab, does a multiply, one 27-step restoring division of d*i
// by the count and an output step, and goes idle once per segment; a two-deep job
// queue lets the front end work on the next point while dabs of the previous
// segment are still going out, and the point input stalls when the queue is full.
// A first point of a stroke is only scaled and kept. Output words wait in a register.
module stroke_dab_interpolator (
    input  logic       clk,
    input  logic       rst_n,
    sdi_cfg_if.sink    cfg,
    sdi_point_if.sink  pt,
    sdi_dab_if.source  dab
);
    import sdi_pkg::*;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [SPC_W-1:0]  spacing_reg;
    logic              fq_valid, fq_ready, qb_valid, qb_ready;
    seg_t              fq_seg, qb_seg;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= SIZE_W'(1024);
            height_reg <= SIZE_W'(1024);
            spacing_reg <= SPC_W'(256);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WIDTH:   width_reg <= cfg.data[SIZE_W-1:0];
                REG_HEIGHT:  height_reg <= cfg.data[SIZE_W-1:0];
                REG_SPACING: spacing_reg <= cfg.data[SPC_W-1:0];
                default: ;
            endcase
        end
    end

    sdi_front u_front (
        .clk, .rst_n, .pt,
        .canvas_width(width_reg), .canvas_height(height_reg),
        .dab_spacing(spacing_reg),
        .seg_valid(fq_valid), .seg_ready(fq_ready), .seg(fq_seg)
    );

    sdi_queue u_queue (
        .clk, .rst_n,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_seg),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_seg)
    );

    sdi_back u_back (
        .clk, .rst_n,
        .seg_valid(qb_valid), .seg_ready(qb_ready), .seg(qb_seg), .dab
    );
endmodule

/* sv/sdi_front.sv */
// Front end: scales points, forms segments, finds length and dab count.
module sdi_front (
    input  logic                      clk,
    input  logic                      rst_n,
    sdi_point_if.sink                 pt,
    input  logic [sdi_pkg::SIZE_W-1:0] canvas_width,
    input  logic [sdi_pkg::SIZE_W-1:0] canvas_height,
    input  logic [sdi_pkg::SPC_W-1:0]  dab_spacing,
    output logic                      seg_valid,
    input  logic                      seg_ready,
    output sdi_pkg::seg_t             seg
);
    import sdi_pkg::*;

    localparam int SQ_W = 2 * VEC_W;     // dx^2 + dy^2 fits in 42 bits
    localparam int RT_W = 23;            // root bound 2^22
    localparam int LEN_W = 13;           // ceil length in pixels <= 5793
    localparam int NUM_W = LEN_W + 8;
    localparam int QUO_W = NUM_W;
    localparam int SQ_STEPS = 23;

    fe_state_t        state_reg, state_next;
    logic [NORM_W-1:0] nx_reg, ny_reg;
    logic             start_reg;
    logic [POS_W-1:0]  prev_x_reg, prev_y_reg;
    logic             have_prev_reg;
    logic [POS_W-1:0]  px_reg, py_reg;
    logic [VEC_W-1:0]  dx_reg, dy_reg;
    logic [SQ_W-1:0]   l2_reg;
    logic [RT_W-1:0]   rt_reg;
    logic [4:0]        step_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [NUM_W-1:0]  num_reg;

    logic [SIZE_W-1:0] wsat, hsat;
    logic [NORM_W+SIZE_W-1:0] sx_full, sy_full;
    logic [POS_W-1:0]  sx, sy;
    logic [SQ_W-1:0]   sqx, sqy;
    logic [SQ_W-1:0]   l2r;
    logic [RT_W-1:0]   trial;
    logic [2*RT_W-1:0] trial_sq;
    logic [RT_W-1:0]   rt_fin;
    logic [NUM_W:0]    rem_sh;
    logic [SPC_W-1:0]  sp;
    logic [NUM_W-1:0]  div_bit;
    logic [RT_W-1:0]   root;
    logic              at_origin;

    // clamp canvas sizes
    assign wsat = (canvas_width > SIZE_W'(MAX_CANVAS)) ? SIZE_W'(MAX_CANVAS) : canvas_width;
    assign hsat = (canvas_height > SIZE_W'(MAX_CANVAS)) ? SIZE_W'(MAX_CANVAS) : canvas_height;
    assign sx_full = nx_reg * wsat;
    assign sy_full = ny_reg * hsat;
    assign sx = (sx_full[NORM_W+SIZE_W-1:8] > (NORM_W+SIZE_W-8)'(20'hFFFFF)) ?
                20'hFFFFF : sx_full[POS_W+7:8];
    assign sy = (sy_full[NORM_W+SIZE_W-1:8] > (NORM_W+SIZE_W-8)'(20'hFFFFF)) ?
                20'hFFFFF : sy_full[POS_W+7:8];

    assign sqx = $signed(dx_reg) * $signed(dx_reg);
    assign sqy = $signed(dy_reg) * $signed(dy_reg);

    // bitwise root: largest r with r*r < v, then ceil = r+1 (v>0)
    assign l2r = (l2_reg + SQ_W'(65535)) >> 16;
    assign trial = rt_reg | (RT_W'(1) << step_reg);
    assign trial_sq = trial * trial;
    assign rt_fin = (trial_sq < (2*RT_W)'(l2r)) ? trial : rt_reg;
    assign at_origin = (l2r == '0);
    assign root = at_origin ? '0 : rt_fin + RT_W'(1);

    assign sp = (dab_spacing < SPC_W'(256)) ? SPC_W'(256) : dab_spacing;
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign div_bit = '0;

    assign pt.ready = (state_reg == FE_IDLE);
    assign seg_valid = (state_reg == FE_PUSH);

    // segment job output
    always_comb
    begin
        seg.prev_x = prev_x_reg;
        seg.prev_y = prev_y_reg;
        seg.dx = dx_reg;
        seg.dy = dy_reg;
        if (quo_reg == '0)
        begin
            seg.cnt = CNT_W'(1);
            seg.clip = 1'b0;
        end
        else if (quo_reg > QUO_W'(MAX_DABS))
        begin
            seg.cnt = CNT_W'(MAX_DABS);
            seg.clip = 1'b1;
        end
        else
        begin
            seg.cnt = quo_reg[CNT_W-1:0];
            seg.clip = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FE_IDLE:  if (pt.valid) state_next = FE_SCALE;
            FE_SCALE: state_next = (start_reg || !have_prev_reg) ? FE_IDLE : FE_SQ;
            FE_SQ:    state_next = FE_SQRT;
            FE_SQRT:  if (step_reg == '0) state_next = FE_DIV;
            FE_DIV:   if (step_reg == '0) state_next = FE_PUSH;
            FE_PUSH:  if (seg_ready) state_next = FE_IDLE;
            default:  state_next = FE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FE_SCALE && (start_reg || !have_prev_reg))
            begin
                prev_x_reg <= sx;
                prev_y_reg <= sy;
                have_prev_reg <= 1'b1;
            end
            if (state_reg == FE_PUSH && seg_ready)
            begin
                prev_x_reg <= px_reg;
                prev_y_reg <= py_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            FE_IDLE:
            begin
                nx_reg <= pt.norm_x;
                ny_reg <= pt.norm_y;
                start_reg <= pt.stroke_start;
            end
            FE_SCALE:
            begin
                px_reg <= sx;
                py_reg <= sy;
                dx_reg <= VEC_W'({1'b0, sx}) - VEC_W'({1'b0, prev_x_reg});
                dy_reg <= VEC_W'({1'b0, sy}) - VEC_W'({1'b0, prev_y_reg});
            end
            FE_SQ:
            begin
                l2_reg <= sqx + sqy;
                rt_reg <= '0;
                step_reg <= 5'(SQ_STEPS - 1);
            end
            FE_SQRT:
            begin
                rt_reg <= rt_fin;
                if (step_reg == '0)
                begin
                    num_reg <= NUM_W'(root[LEN_W-1:0]) << 8;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    step_reg <= 5'(NUM_W - 1);
                end
                else
                    step_reg <= step_reg - 5'd1;
            end
            FE_DIV:
            begin
                num_reg <= num_reg << 1;
                if (rem_sh >= (NUM_W+1)'(sp))
                begin
                    rem_reg <= NUM_W'(rem_sh - (NUM_W+1)'(sp));
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1} | div_bit;
                end
                else
                begin
                    rem_reg <= rem_sh[NUM_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                if (step_reg != '0)
                    step_reg <= step_reg - 5'd1;
            end
            FE_PUSH: ;
            default: ;
        endcase
    end
endmodule

/* sv/sdi_queue.sv */
// Short job queue between the front end and the dab generator.
module sdi_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sdi_pkg::seg_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sdi_pkg::seg_t out_data
);
    import sdi_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    seg_t          mem_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + PW'(1);
            if (pop) rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_data;
    end
endmodule

/* sv/sdi_back.sv */
// Back end: steps through the dabs of one segment and takes the next segment only after its last dab is out.
module sdi_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seg_valid,
    output logic          seg_ready,
    input  sdi_pkg::seg_t seg,
    sdi_dab_if.source     dab
);
    import sdi_pkg::*;

    localparam int PR_W = VEC_W + IDX_W;   // d*i
    localparam int DV_W = PR_W;

    be_state_t         state_reg, state_next;
    logic              dab_valid_next;
    seg_t              job_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [DV_W-1:0]   ax_reg, ay_reg;   // magnitudes
    logic              nx_reg, ny_reg;
    logic [DV_W-1:0]   qx_reg, qy_reg, rx_reg, ry_reg;
    logic [4:0]        k_reg;
    logic [DV_W:0]     rxs, rys;
    logic [DV_W-1:0]   cntw;
    logic signed [PR_W-1:0] px, py;
    logic [DV_W-1:0]   fx, fy;
    logic              ox_ready;
    logic              last_dab;

    assign cntw = DV_W'(job_reg.cnt);
    assign px = $signed(job_reg.dx) * $signed({1'b0, i_reg[IDX_W-1:0]});
    assign py = $signed(job_reg.dy) * $signed({1'b0, i_reg[IDX_W-1:0]});
    assign rxs = {rx_reg, ax_reg[DV_W-1]};
    assign rys = {ry_reg, ay_reg[DV_W-1]};
    // floor for negatives: -(q + (r!=0))
    assign fx = nx_reg ? (~qx_reg + DV_W'(1) - DV_W'(rx_reg != '0)) : qx_reg;
    assign fy = ny_reg ? (~qy_reg + DV_W'(1) - DV_W'(ry_reg != '0)) : qy_reg;

    assign seg_ready = (state_reg == BE_IDLE);
    assign ox_ready = dab.ready || !dab.valid;
    assign last_dab = (i_reg + CNT_W'(1) == job_reg.cnt);

    // next state and output valid
    always_comb
    begin
        state_next = state_reg;
        dab_valid_next = dab.valid && !dab.ready;
        unique case (state_reg)
            BE_IDLE: if (seg_valid) state_next = BE_MUL;
            BE_MUL:  state_next = BE_DIV;
            BE_DIV:  if (k_reg == '0) state_next = BE_OUT;
            BE_OUT:
                if (ox_ready)
                begin
                    dab_valid_next = 1'b1;
                    state_next = last_dab ? BE_IDLE : BE_MUL;
                end
            default: state_next = BE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
            dab.valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dab.valid <= dab_valid_next;
        end
    end

    // job load, d*i multiply, offset division d*i/cnt (restoring, one bit a cycle) and dab output
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BE_IDLE:
            begin
                job_reg <= seg;
                i_reg <= '0;
            end
            BE_MUL:
            begin
                nx_reg <= px[PR_W-1];
                ny_reg <= py[PR_W-1];
                ax_reg <= px[PR_W-1] ? DV_W'(-px) : DV_W'(px);
                ay_reg <= py[PR_W-1] ? DV_W'(-py) : DV_W'(py);
                rx_reg <= '0;
                ry_reg <= '0;
                qx_reg <= '0;
                qy_reg <= '0;
                k_reg <= 5'(DV_W - 1);
            end
            BE_DIV:
            begin
                ax_reg <= ax_reg << 1;
                ay_reg <= ay_reg << 1;
                if (rxs >= (DV_W+1)'(cntw))
                begin
                    rx_reg <= DV_W'(rxs - (DV_W+1)'(cntw));
                    qx_reg <= {qx_reg[DV_W-2:0], 1'b1};
                end
                else
                begin
                    rx_reg <= rxs[DV_W-1:0];
                    qx_reg <= {qx_reg[DV_W-2:0], 1'b0};
                end
                if (rys >= (DV_W+1)'(cntw))
                begin
                    ry_reg <= DV_W'(rys - (DV_W+1)'(cntw));
                    qy_reg <= {qy_reg[DV_W-2:0], 1'b1};
                end
                else
                begin
                    ry_reg <= rys[DV_W-1:0];
                    qy_reg <= {qy_reg[DV_W-2:0], 1'b0};
                end
                if (k_reg != '0) k_reg <= k_reg - 5'd1;
            end
            BE_OUT:
                if (ox_ready)
                begin
                    dab.dab_x <= job_reg.prev_x + fx[POS_W-1:0];
                    dab.dab_y <= job_reg.prev_y + fy[POS_W-1:0];
                    dab.seg_dx <= job_reg.dx;
                    dab.seg_dy <= job_reg.dy;
                    dab.last <= last_dab;
                    dab.clipped <= job_reg.clip;
                    i_reg <= i_reg + CNT_W'(1);
                end
            default: ;
        endcase
    end
endmodule
